// File: rtl/spin_thrust_motion_detector_defines.svh
// ----------------------------------------------------------------------------
// Spin/thrust motion detector assertion macros
// Shared property shapes for the concurrent checks of the detector.
// ----------------------------------------------------------------------------
`ifndef SPIN_THRUST_MOTION_DETECTOR_DEFINES_SVH
`define SPIN_THRUST_MOTION_DETECTOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define STMD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define STMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/stmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spin/thrust motion detector package
// Widths, codes, register reset values and shared types.
// ----------------------------------------------------------------------------
package stmd_pkg;

   // Block length is 2^SAMPLES_LOG2 samples (legal range 1 to 16).
   localparam int SAMPLES_LOG2 = 9;
   localparam int SAMPLE_W     = 12;
   localparam int COUNT_W      = SAMPLES_LOG2 + 1;
   localparam int SUM_W        = SAMPLE_W + SAMPLES_LOG2;
   localparam int TARGET_W     = 4;
   localparam int FUNC_W       = 2;
   localparam int MODE_W       = 2;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 12;

   localparam logic [COUNT_W-1:0] BLOCK_LEN = {1'b1, {SAMPLES_LOG2{1'b0}}};
   localparam logic [TARGET_W-1:0] BLOCK_CNT_MAX = '1;

   // Command codes
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SPIN   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_THRUST = 2'd2;

   // Tracking mode codes
   localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SPIN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_THRUST = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SPIN_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRUST_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPIN_TARGET      = 2'd2;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] SPIN_THRESHOLD_RST   = 12'd2400;
   localparam logic [SAMPLE_W-1:0] THRUST_THRESHOLD_RST = 12'd2000;
   localparam logic [TARGET_W-1:0] SPIN_TARGET_RST      = 4'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] spin_threshold;
      logic [SAMPLE_W-1:0] thrust_threshold;
      logic [TARGET_W-1:0] spin_block_target;
   } cfg_type;

   typedef struct packed {
      logic                spin_complete;
      logic                thrust_complete;
      logic                block_done;
      logic [SAMPLE_W-1:0] block_average;
      logic [MODE_W-1:0]   tracking_mode;
   } result_type;

endpackage

// File: rtl/spin_thrust_motion_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spin/thrust motion detector
// Tracks spin (block averages) or thrust (single sample) gestures on a
// stream of 12-bit accelerometer readings.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one transaction carries a command in req_func
//   (sample tick, start spin, start thrust) and a converter reading in
//   req_adc_sample. Response channel (rsp_*): exactly one transaction per
//   request, showing the status after that request.
//   Both channels use valid/stall; a transaction moves when valid is high
//   and stall is low.
//   The response passes through the input register, then the result
//   register, where a high rsp_stall can hold it. Throughput: one
//   transaction per cycle while rsp_stall is low; the tracking update is a
//   single add, compare and count pass between the two registers.
//   When rsp_stall is high the result register holds; the input register
//   still takes one more transaction before req_stall rises.
//   Reset (synchronous, active high) empties both registers, clears all
//   tracking state and loads the register defaults (2400, 2000, 3).
//   Write csr_* only while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "spin_thrust_motion_detector_defines.svh"

module spin_thrust_motion_detector (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [stmd_pkg::FUNC_W-1:0]         req_func,
   input  logic [stmd_pkg::SAMPLE_W-1:0]       req_adc_sample,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_spin_complete,
   output logic                                rsp_thrust_complete,
   output logic                                rsp_block_done,
   output logic [stmd_pkg::SAMPLE_W-1:0]       rsp_block_average,
   output logic [stmd_pkg::MODE_W-1:0]         rsp_tracking_mode,
   // configuration write port
   input  logic                                csr_write,
   input  logic [stmd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [stmd_pkg::CSR_DATA_W-1:0]     csr_data
);

   stmd_pkg::cfg_type                 cfg;
   stmd_pkg::result_type              result;
   stmd_pkg::result_type              result_ff;

   logic                              in_valid_ff;
   logic [stmd_pkg::FUNC_W-1:0]       in_func_ff;
   logic [stmd_pkg::SAMPLE_W-1:0]     in_sample_ff;
   logic                              rsp_valid_ff;

   logic                              req_accept;
   logic                              advance;

   // Move the held request into the result register unless the result
   // register is full and the receiver is stalling.
   assign advance    = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   // Stall the sender only when both registers are occupied and the
   // head cannot drain.
   assign req_stall  = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   stmd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Tracking state advances only when its transaction moves on, so a
   // stall never repeats or loses an update.
   stmd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .func       (in_func_ff),
      .adc_sample (in_sample_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // Input register: load on acceptance, empty once it has advanced.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff   <= req_func;
         in_sample_ff <= req_adc_sample;
      end
   end

   // Result register: fill on advance, drain when the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_spin_complete   = result_ff.spin_complete;
   assign rsp_thrust_complete = result_ff.thrust_complete;
   assign rsp_block_done      = result_ff.block_done;
   assign rsp_block_average   = result_ff.block_average;
   assign rsp_tracking_mode   = result_ff.tracking_mode;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `STMD_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_accept, in_valid_ff,
      "accepted request not held in input register")
   `STMD_ASSERT_NEXT(a_spin_start_mode, clock, reset,
      advance && (in_func_ff == stmd_pkg::FUNC_SPIN),
      rsp_valid_ff && (result_ff.tracking_mode == stmd_pkg::MODE_SPIN),
      "spin start did not report spin tracking")
   `STMD_ASSERT_SAME(a_thrust_done_stops, clock, reset,
      rsp_valid_ff && result_ff.thrust_complete,
      result_ff.tracking_mode != stmd_pkg::MODE_THRUST,
      "thrust still tracked after completion")

endmodule

// File: rtl/stmd_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spin/thrust motion detector configuration registers
// Threshold and target registers behind a plain write port.
// ----------------------------------------------------------------------------
module stmd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [stmd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [stmd_pkg::CSR_DATA_W-1:0]     csr_data,
   output stmd_pkg::cfg_type                   cfg
);

   stmd_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spin_threshold    <= stmd_pkg::SPIN_THRESHOLD_RST;
         cfg_ff.thrust_threshold  <= stmd_pkg::THRUST_THRESHOLD_RST;
         cfg_ff.spin_block_target <= stmd_pkg::SPIN_TARGET_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            stmd_pkg::CSR_SPIN_THRESHOLD: begin
               cfg_ff.spin_threshold <= csr_data[stmd_pkg::SAMPLE_W-1:0];
            end
            stmd_pkg::CSR_THRUST_THRESHOLD: begin
               cfg_ff.thrust_threshold <= csr_data[stmd_pkg::SAMPLE_W-1:0];
            end
            stmd_pkg::CSR_SPIN_TARGET: begin
               cfg_ff.spin_block_target <= csr_data[stmd_pkg::TARGET_W-1:0];
            end
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/stmd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spin/thrust motion detector tracking core
// Tracking state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module stmd_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [stmd_pkg::FUNC_W-1:0]       func,
   input  logic [stmd_pkg::SAMPLE_W-1:0]     adc_sample,
   input  stmd_pkg::cfg_type                 cfg,
   output stmd_pkg::result_type              result
);

   logic                              spin_active_ff,   spin_active_in;
   logic                              thrust_active_ff, thrust_active_in;
   logic [stmd_pkg::COUNT_W-1:0]      sample_count_ff,  sample_count_in;
   logic [stmd_pkg::SUM_W-1:0]        sample_sum_ff,    sample_sum_in;
   logic [stmd_pkg::TARGET_W-1:0]     block_counter_ff, block_counter_in;
   logic                              thrust_seen_ff,   thrust_seen_in;

   logic [stmd_pkg::COUNT_W-1:0]      count_inc;
   logic [stmd_pkg::SUM_W-1:0]        sum_inc;
   logic [stmd_pkg::SAMPLE_W-1:0]     average;
   logic                              done;

   assign count_inc = sample_count_ff + stmd_pkg::COUNT_W'(1);
   assign sum_inc   = sample_sum_ff + stmd_pkg::SUM_W'(adc_sample);
   assign average   = sum_inc[stmd_pkg::SUM_W-1:stmd_pkg::SAMPLES_LOG2];

   always_comb begin
      spin_active_in   = spin_active_ff;
      thrust_active_in = thrust_active_ff;
      sample_count_in  = sample_count_ff;
      sample_sum_in    = sample_sum_ff;
      block_counter_in = block_counter_ff;
      thrust_seen_in   = thrust_seen_ff;
      done             = 1'b0;
      unique case (func)
         stmd_pkg::FUNC_SPIN: begin
            spin_active_in   = 1'b1;
            thrust_active_in = 1'b0;
            block_counter_in = '0;
            sample_sum_in    = '0;
            sample_count_in  = '0;
         end
         stmd_pkg::FUNC_THRUST: begin
            // block counter is kept
            thrust_seen_in   = 1'b0;
            spin_active_in   = 1'b0;
            thrust_active_in = 1'b1;
         end
         stmd_pkg::FUNC_SAMPLE: begin
            if (spin_active_ff) begin
               if (count_inc == stmd_pkg::BLOCK_LEN) begin
                  done            = 1'b1;
                  sample_count_in = '0;
                  sample_sum_in   = '0;
                  if (average < cfg.spin_threshold) begin
                     block_counter_in = '0;
                  end else if (block_counter_ff != stmd_pkg::BLOCK_CNT_MAX) begin
                     block_counter_in = block_counter_ff + stmd_pkg::TARGET_W'(1);
                  end
                  if (block_counter_in == cfg.spin_block_target) begin
                     spin_active_in = 1'b0;
                  end
               end else begin
                  sample_count_in = count_inc;
                  sample_sum_in   = sum_inc;
               end
            end else if (thrust_active_ff) begin
               thrust_seen_in = (adc_sample > cfg.thrust_threshold);
               if (thrust_seen_in) begin
                  thrust_active_in = 1'b0;
               end
            end
         end
         default: begin
            // unused command: report status only
         end
      endcase
   end

   always_comb begin
      result.spin_complete   = (block_counter_in == cfg.spin_block_target);
      result.thrust_complete = thrust_seen_in;
      result.block_done      = done;
      result.block_average   = done ? average : '0;
      if (spin_active_in) begin
         result.tracking_mode = stmd_pkg::MODE_SPIN;
      end else if (thrust_active_in) begin
         result.tracking_mode = stmd_pkg::MODE_THRUST;
      end else begin
         result.tracking_mode = stmd_pkg::MODE_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spin_active_ff   <= 1'b0;
         thrust_active_ff <= 1'b0;
         sample_count_ff  <= '0;
         sample_sum_ff    <= '0;
         block_counter_ff <= '0;
         thrust_seen_ff   <= 1'b0;
      end else if (advance) begin
         spin_active_ff   <= spin_active_in;
         thrust_active_ff <= thrust_active_in;
         sample_count_ff  <= sample_count_in;
         sample_sum_ff    <= sample_sum_in;
         block_counter_ff <= block_counter_in;
         thrust_seen_ff   <= thrust_seen_in;
      end
   end

endmodule

// File: test/tb_spin_thrust_motion_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spin/thrust motion detector testbench
// Drives sample ticks and start commands through the valid/stall request
// channel and keeps its own model of the tracking state. Every response is
// checked field by field against that model or a typed script row. A short
// scripted table comes first. Register phases with random gesture episodes
// follow, one of them carrying a full spin block through to spin complete.
// ----------------------------------------------------------------------------
module tb_spin_thrust_motion_detector;

   // Codes the package leaves unnamed
   localparam logic [stmd_pkg::FUNC_W-1:0]      FUNC_UNUSED = 2'd3;
   localparam logic [stmd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam int IDLE_PERCENT = 23;
   localparam int MAX_REPORTS  = 10;
   localparam int SCRIPT_ROWS  = 19;

   typedef enum {BIAS_HIGH, BIAS_LOW, BIAS_ANY} bias_type;

   typedef struct {
      logic [stmd_pkg::FUNC_W-1:0]   func;
      logic [stmd_pkg::SAMPLE_W-1:0] sample;
      bit                            typed;
      stmd_pkg::result_type          status;
   } script_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [stmd_pkg::FUNC_W-1:0]      req_func = stmd_pkg::FUNC_SAMPLE;
   logic [stmd_pkg::SAMPLE_W-1:0]    req_adc_sample = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_spin_complete;
   logic                             rsp_thrust_complete;
   logic                             rsp_block_done;
   logic [stmd_pkg::SAMPLE_W-1:0]    rsp_block_average;
   logic [stmd_pkg::MODE_W-1:0]      rsp_tracking_mode;
   logic                             csr_write = 1'b0;
   logic [stmd_pkg::CSR_INDEX_W-1:0] csr_index = stmd_pkg::CSR_SPIN_THRESHOLD;
   logic [stmd_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // Model of the tracking state and the registers
   stmd_pkg::cfg_type             regs;
   logic                          spin_on;
   logic                          thrust_on;
   logic [stmd_pkg::COUNT_W-1:0]  acc_count;
   logic [stmd_pkg::SUM_W-1:0]    acc_sum;
   logic [stmd_pkg::TARGET_W-1:0] good_blocks;
   logic                          thrust_hit;

   stmd_pkg::result_type pending_status[$];
   int                   status_mismatches = 0;
   int                   items_sent = 0;
   bit                   idle_en = 1'b1;
   bit                   stall_en = 1'b1;

   // Scripted opening. Typed rows run at the reset registers (target 3) with
   // the block counter still zero, so spin complete stays low throughout.
   script_row_type script [SCRIPT_ROWS] = '{
      // samples and the unused code while idle are ignored
      '{stmd_pkg::FUNC_SAMPLE, 12'd0,    1'b1, '{1'b0, 1'b0, 1'b0, 12'd0, stmd_pkg::MODE_IDLE}},
      '{stmd_pkg::FUNC_SAMPLE, 12'd4095, 1'b1, '{1'b0, 1'b0, 1'b0, 12'd0, stmd_pkg::MODE_IDLE}},
      '{FUNC_UNUSED,           12'd4095, 1'b1, '{1'b0, 1'b0, 1'b0, 12'd0, stmd_pkg::MODE_IDLE}},
      // thrust: equal to the threshold does not count, one above does
      '{stmd_pkg::FUNC_THRUST, 12'd0,    1'b1,
        '{1'b0, 1'b0, 1'b0, 12'd0, stmd_pkg::MODE_THRUST}},
      '{stmd_pkg::FUNC_SAMPLE, 12'd2000, 1'b1,
        '{1'b0, 1'b0, 1'b0, 12'd0, stmd_pkg::MODE_THRUST}},
      '{stmd_pkg::FUNC_SAMPLE, 12'd2001, 1'b1, '{1'b0, 1'b1, 1'b0, 12'd0, stmd_pkg::MODE_IDLE}},
      '{stmd_pkg::FUNC_SAMPLE, 12'd4095, 1'b1, '{1'b0, 1'b1, 1'b0, 12'd0, stmd_pkg::MODE_IDLE}},
      // a new thrust start clears thrust complete
      '{stmd_pkg::FUNC_THRUST, 12'd4095, 1'b1,
        '{1'b0, 1'b0, 1'b0, 12'd0, stmd_pkg::MODE_THRUST}},
      '{stmd_pkg::FUNC_SAMPLE, 12'd0,    1'b1,
        '{1'b0, 1'b0, 1'b0, 12'd0, stmd_pkg::MODE_THRUST}},
      '{stmd_pkg::FUNC_SAMPLE, 12'd4095, 1'b1, '{1'b0, 1'b1, 1'b0, 12'd0, stmd_pkg::MODE_IDLE}},
      // starting a spin leaves thrust complete alone
      '{stmd_pkg::FUNC_SPIN,   12'd0,    1'b1, '{1'b0, 1'b1, 1'b0, 12'd0, stmd_pkg::MODE_SPIN}},
      '{stmd_pkg::FUNC_SAMPLE, 12'd4095, 1'b1, '{1'b0, 1'b1, 1'b0, 12'd0, stmd_pkg::MODE_SPIN}},
      '{FUNC_UNUSED,           12'd0,    1'b1, '{1'b0, 1'b1, 1'b0, 12'd0, stmd_pkg::MODE_SPIN}},
      // thrust start aborts the spin
      '{stmd_pkg::FUNC_THRUST, 12'd0,    1'b1,
        '{1'b0, 1'b0, 1'b0, 12'd0, stmd_pkg::MODE_THRUST}},
      '{stmd_pkg::FUNC_SAMPLE, 12'd0,    1'b1,
        '{1'b0, 1'b0, 1'b0, 12'd0, stmd_pkg::MODE_THRUST}},
      '{stmd_pkg::FUNC_SPIN,   12'd4095, 1'b1, '{1'b0, 1'b0, 1'b0, 12'd0, stmd_pkg::MODE_SPIN}},
      // partial block in progress, left to the model
      '{stmd_pkg::FUNC_SAMPLE, 12'd0,    1'b0, '0},
      '{stmd_pkg::FUNC_SAMPLE, 12'd4095, 1'b0, '0},
      '{FUNC_UNUSED,           12'd2048, 1'b0, '0}
   };

   spin_thrust_motion_detector dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_adc_sample      (req_adc_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_spin_complete   (rsp_spin_complete),
      .rsp_thrust_complete (rsp_thrust_complete),
      .rsp_block_done      (rsp_block_done),
      .rsp_block_average   (rsp_block_average),
      .rsp_tracking_mode   (rsp_tracking_mode),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advance the tracking model by one transaction and return the status
   // the block should report for it.
   function automatic stmd_pkg::result_type advance_detector(
      input logic [stmd_pkg::FUNC_W-1:0]   f,
      input logic [stmd_pkg::SAMPLE_W-1:0] s);
      stmd_pkg::result_type          status;
      logic [stmd_pkg::SAMPLE_W-1:0] avg_v;
      status = '0;
      unique case (f)
         stmd_pkg::FUNC_SPIN: begin
            spin_on     = 1'b1;
            thrust_on   = 1'b0;
            good_blocks = '0;
            acc_sum     = '0;
            acc_count   = '0;
         end
         stmd_pkg::FUNC_THRUST: begin
            thrust_hit = 1'b0;
            spin_on    = 1'b0;
            thrust_on  = 1'b1;
         end
         stmd_pkg::FUNC_SAMPLE: begin
            if (spin_on) begin
               if (acc_count < stmd_pkg::BLOCK_LEN) begin
                  acc_sum   = acc_sum + stmd_pkg::SUM_W'(s);
                  acc_count = acc_count + stmd_pkg::COUNT_W'(1);
               end
               if (acc_count == stmd_pkg::BLOCK_LEN) begin
                  avg_v = stmd_pkg::SAMPLE_W'(acc_sum >> stmd_pkg::SAMPLES_LOG2);
                  status.block_done    = 1'b1;
                  status.block_average = avg_v;
                  acc_count = '0;
                  acc_sum   = '0;
                  // a weak block breaks the run, a strong one extends it
                  if (avg_v < regs.spin_threshold) begin
                     good_blocks = '0;
                  end else if (good_blocks != stmd_pkg::BLOCK_CNT_MAX) begin
                     good_blocks = good_blocks + stmd_pkg::TARGET_W'(1);
                  end
                  if (good_blocks == regs.spin_block_target) begin
                     spin_on = 1'b0;
                  end
               end
            end else if (thrust_on) begin
               thrust_hit = (s > regs.thrust_threshold);
               if (thrust_hit) begin
                  thrust_on = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      status.spin_complete   = (good_blocks == regs.spin_block_target);
      status.thrust_complete = thrust_hit;
      status.tracking_mode   = spin_on ? stmd_pkg::MODE_SPIN :
                               (thrust_on ? stmd_pkg::MODE_THRUST : stmd_pkg::MODE_IDLE);
      return status;
   endfunction

   // Offer one request transaction, with a random gap in front of it, and
   // hold it until the block takes it. Valid stays high on return.
   task automatic send_item(input logic [stmd_pkg::FUNC_W-1:0] f,
                            input logic [stmd_pkg::SAMPLE_W-1:0] s,
                            input bit typed = 1'b0,
                            input stmd_pkg::result_type typed_status = '0);
      stmd_pkg::result_type predicted;
      while (idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_adc_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_detector(f, s);
      pending_status.push_back(typed ? typed_status : predicted);
      items_sent++;
   endtask

   // Drop valid and wait until every response has come back.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all three registers plus the unused index. Only call when drained.
   task automatic program_regs(input logic [stmd_pkg::CSR_DATA_W-1:0] spin_thr,
                               input logic [stmd_pkg::CSR_DATA_W-1:0] thrust_thr,
                               input logic [stmd_pkg::CSR_DATA_W-1:0] target_word);
      csr_write <= 1'b1;
      csr_index <= stmd_pkg::CSR_SPIN_THRESHOLD;
      csr_data  <= spin_thr;
      @(posedge clock);
      csr_index <= stmd_pkg::CSR_THRUST_THRESHOLD;
      csr_data  <= thrust_thr;
      @(posedge clock);
      csr_index <= stmd_pkg::CSR_SPIN_TARGET;
      csr_data  <= target_word;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_data  <= stmd_pkg::CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_write <= 1'b0;
      regs.spin_threshold    = spin_thr[stmd_pkg::SAMPLE_W-1:0];
      regs.thrust_threshold  = thrust_thr[stmd_pkg::SAMPLE_W-1:0];
      regs.spin_block_target = target_word[stmd_pkg::TARGET_W-1:0];
   endtask

   // Feed spin samples that sit above, below or anywhere around the threshold.
   task automatic feed_spin_samples(input bias_type bias, input int count);
      int thr;
      int s;
      thr = int'(regs.spin_threshold);
      repeat (count) begin
         case (bias)
            BIAS_HIGH: s = $urandom_range(thr, 4095);
            BIAS_LOW:  s = (thr == 0) ? 0 : $urandom_range(0, thr - 1);
            default:   s = $urandom_range(0, 4095);
         endcase
         // the odd unused code in mid-block must not disturb the sum
         if ($urandom_range(0, 255) == 0) begin
            send_item(FUNC_UNUSED, stmd_pkg::SAMPLE_W'($urandom));
         end
         send_item(stmd_pkg::FUNC_SAMPLE, stmd_pkg::SAMPLE_W'(s));
      end
   endtask

   task automatic spin_episode(input int blocks);
      int roll;
      send_item(stmd_pkg::FUNC_SPIN, stmd_pkg::SAMPLE_W'($urandom));
      repeat (blocks) begin
         roll = $urandom_range(0, 3);
         feed_spin_samples(roll < 2 ? BIAS_HIGH : (roll == 2 ? BIAS_LOW : BIAS_ANY),
                           int'(stmd_pkg::BLOCK_LEN));
      end
      // sometimes follow with a short tail of samples and a thrust start
      if ($urandom_range(0, 9) == 0) begin
         feed_spin_samples(BIAS_ANY, $urandom_range(1, 15));
         send_item(stmd_pkg::FUNC_THRUST, stmd_pkg::SAMPLE_W'($urandom));
      end
   endtask

   task automatic thrust_episode();
      int thr;
      thr = int'(regs.thrust_threshold);
      send_item(stmd_pkg::FUNC_THRUST, stmd_pkg::SAMPLE_W'($urandom));
      repeat ($urandom_range(0, 6)) begin
         send_item(stmd_pkg::FUNC_SAMPLE, stmd_pkg::SAMPLE_W'($urandom_range(0, thr)));
      end
      if (thr != 4095 && $urandom_range(0, 3) != 0) begin
         send_item(stmd_pkg::FUNC_SAMPLE, stmd_pkg::SAMPLE_W'($urandom_range(thr + 1, 4095)));
      end
      repeat ($urandom_range(0, 2)) begin
         send_item(stmd_pkg::FUNC_SAMPLE, stmd_pkg::SAMPLE_W'($urandom));
      end
   endtask

   task automatic random_phase(input int min_items);
      int first;
      int pick;
      first = items_sent;
      while (items_sent - first < min_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            thrust_episode();
         end else begin
            repeat ($urandom_range(1, 8)) begin
               send_item(stmd_pkg::FUNC_W'($urandom_range(0, 3)),
                         stmd_pkg::SAMPLE_W'($urandom));
            end
         end
      end
      drain_pipeline();
   endtask

   // Response side: stall at random unless a quiet stretch is running.
   always @(posedge clock) begin
      rsp_stall <= stall_en && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   task automatic report_mismatch(input string what, input stmd_pkg::result_type want,
                                  input stmd_pkg::result_type got);
      status_mismatches++;
      if (status_mismatches <= MAX_REPORTS) begin
         $write("%0t: %s: expected spin %0b thrust %0b done %0b avg %0d mode %0d, ",
                $realtime, what, want.spin_complete, want.thrust_complete,
                want.block_done, want.block_average, want.tracking_mode);
         $display("got spin %0b thrust %0b done %0b avg %0d mode %0d",
                  got.spin_complete, got.thrust_complete, got.block_done,
                  got.block_average, got.tracking_mode);
      end
   endtask

   // Check each accepted response against the oldest prediction.
   always @(posedge clock) begin
      stmd_pkg::result_type got;
      stmd_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_spin_complete, rsp_thrust_complete, rsp_block_done,
                rsp_block_average, rsp_tracking_mode};
         if (pending_status.size() == 0) begin
            report_mismatch("response with nothing outstanding", '0, got);
         end else begin
            want = pending_status.pop_front();
            if (got.spin_complete   !== want.spin_complete   ||
                got.thrust_complete !== want.thrust_complete ||
                got.block_done      !== want.block_done      ||
                got.block_average   !== want.block_average   ||
                got.tracking_mode   !== want.tracking_mode) begin
               report_mismatch("status mismatch", want, got);
            end
         end
      end
   end

   initial begin
      regs.spin_threshold    = stmd_pkg::SPIN_THRESHOLD_RST;
      regs.thrust_threshold  = stmd_pkg::THRUST_THRESHOLD_RST;
      regs.spin_block_target = stmd_pkg::SPIN_TARGET_RST;
      spin_on     = 1'b0;
      thrust_on   = 1'b0;
      acc_count   = '0;
      acc_sum     = '0;
      good_blocks = '0;
      thrust_hit  = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // scripted opening, at the reset register values
      foreach (script[i]) begin
         send_item(script[i].func, script[i].sample, script[i].typed, script[i].status);
      end
      random_phase(25);

      // every block qualifies, thrust never fires, one block completes a spin;
      // junk in the upper target bits must be masked off. No idling here.
      idle_en  = 1'b0;
      stall_en = 1'b0;
      program_regs(12'd0, 12'd4095, {8'($urandom), 4'd1});
      spin_episode(1);
      random_phase(25);
      idle_en  = 1'b1;
      stall_en = 1'b1;

      // target of zero: complete whenever the counter is zero
      program_regs(12'($urandom_range(1500, 3000)), 12'($urandom), 12'd0);
      random_phase(20);

      // any non-zero sample is a thrust
      program_regs(12'd4095, 12'd0, 12'd15);
      random_phase(20);

      repeat (8) @(posedge clock);
      if (status_mismatches == 0 && pending_status.size() == 0) begin
         $display("spin_thrust_motion_detector verification clean");
      end else begin
         $display("spin_thrust_motion_detector verification failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #(20_000_000);
      $display("spin_thrust_motion_detector verification failed");
      $finish;
   end

endmodule
